// ===== hw/rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the stream find-and-replace core
// Register indexes, byte-width constants and the job descriptor that the
// window chain hands to the emitter.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Register and field widths
  localparam int BYTE_W    = 8;
  localparam int REG_W     = 64;
  localparam int LEN_W     = 4;
  localparam int MAX_BYTES = REG_W / BYTE_W;
  localparam int PTR_W     = $clog2(MAX_BYTES);
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int CFG_IDX_W = 2;

  // Default window depth and the fixed replacement limit
  localparam int PATTERN_MAX_DEF = 8;
  localparam int REPLACEMENT_MAX = 8;
  localparam int RCAP = (REPLACEMENT_MAX < MAX_BYTES) ? REPLACEMENT_MAX : MAX_BYTES;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [MAX_BYTES-1:0][BYTE_W-1:0] byte_row_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES      = 2'd0,
    CFG_PATTERN_LENGTH     = 2'd1,
    CFG_REPLACEMENT_BYTES  = 2'd2,
    CFG_REPLACEMENT_LENGTH = 2'd3
  } cfg_idx_t;

  // One item's worth of results, as decided at accept time
  typedef struct packed {
    logic load;      // item produces at least one result
    logic src_repl;  // bytes come from the replacement register
    logic chars;     // results carry characters (clear on a bare end marker)
    logic str_end;   // last result closes the string
    logic down;      // walk the byte row downwards (oldest window byte first)
    ptr_t ptr;       // first byte position
    cnt_t cnt;       // number of results
  } sfr_job_t;

endpackage

// ===== hw/rtl/stream_find_replace_core.sv =====
// ----------------------------------------------------------------------------
// stream_find_replace_core: streaming find-and-replace-all over byte strings
// Leftmost, non-overlapping replacement of a pattern of up to eight bytes by
// a replacement of up to eight bytes, with flush at the end of each string.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+---------------------------------
//   input    | in_valid / in_ready         | in_byte, in_end
//   result   | out_item_valid / out_ready  | out_byte, out_valid,
//            |                             | out_string_end, out_run_last
//   config   | cfg_wr_en (no wait)         | cfg_index, cfg_wdata
//
// A beat that causes n results holds the emitter until all n have moved out,
// one result per cycle while the output is not stalled. The first result of
// a beat is held in the pending-job registers and then moves into the output
// register. Synchronous reset clears the configuration registers, the fill
// count and both valid flags; the window bytes need no clearing. A stalled
// output holds its beat, and a new input beat is taken once the last result
// has moved into the output register, also while it waits there.
// ----------------------------------------------------------------------------
module stream_find_replace_core #(
  parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfr_pkg::REG_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sfr_pkg::BYTE_W-1:0]      in_byte,
  input  logic                            in_end,
  output logic                            out_item_valid,
  input  logic                            out_ready,
  output logic [sfr_pkg::BYTE_W-1:0]      out_byte,
  output logic                            out_valid,
  output logic                            out_string_end,
  output logic                            out_run_last
);

  logic [sfr_pkg::REG_W-1:0] pat_bytes_r, repl_bytes_r;
  logic [sfr_pkg::LEN_W-1:0] pat_len_r, repl_len_r;
  logic                      pat_len_wr, acc;
  sfr_pkg::sfr_job_t         job;
  sfr_pkg::byte_row_t        win_row;

  assign acc        = in_valid && in_ready;
  assign pat_len_wr = cfg_wr_en &&
                      (sfr_pkg::cfg_idx_t'(cfg_index) == sfr_pkg::CFG_PATTERN_LENGTH);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r  <= '0;
      pat_len_r    <= '0;
      repl_bytes_r <= '0;
      repl_len_r   <= '0;
    end else if (cfg_wr_en) begin
      case (sfr_pkg::cfg_idx_t'(cfg_index))
        sfr_pkg::CFG_PATTERN_BYTES:      pat_bytes_r  <= cfg_wdata;
        sfr_pkg::CFG_PATTERN_LENGTH:     pat_len_r    <= cfg_wdata[sfr_pkg::LEN_W-1:0];
        sfr_pkg::CFG_REPLACEMENT_BYTES:  repl_bytes_r <= cfg_wdata;
        sfr_pkg::CFG_REPLACEMENT_LENGTH: repl_len_r   <= cfg_wdata[sfr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  sfr_window #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .pat_bytes  (pat_bytes_r),
    .pat_len    (pat_len_r),
    .repl_len   (repl_len_r),
    .pat_len_wr (pat_len_wr),
    .acc        (acc),
    .in_byte    (in_byte),
    .in_end     (in_end),
    .job        (job),
    .win_row    (win_row)
  );

  sfr_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (acc),
    .job            (job),
    .win_row        (win_row),
    .repl_bytes     (repl_bytes_r),
    .in_ready       (in_ready),
    .out_item_valid (out_item_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_valid      (out_valid),
    .out_string_end (out_string_end),
    .out_run_last   (out_run_last)
  );

endmodule

// ===== hw/rtl/sfr_cell.sv =====
// ----------------------------------------------------------------------------
// sfr_cell: one window cell
// Holds one byte of the window, takes its neighbour's byte on each accepted
// beat and compares the byte it is about to hold with its pattern byte.
// ----------------------------------------------------------------------------
module sfr_cell (
  input  logic                         clk,
  input  logic                         shift_en,
  input  logic [sfr_pkg::BYTE_W-1:0]   d_in,
  input  logic [sfr_pkg::BYTE_W-1:0]   pat_byte,
  output logic [sfr_pkg::BYTE_W-1:0]   q,
  output logic                         eq
);

  logic [sfr_pkg::BYTE_W-1:0] byte_r;

  // Advance the chain on every accepted beat
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= d_in;
    end
  end

  assign q  = byte_r;
  assign eq = (d_in == pat_byte);

endmodule

// ===== hw/rtl/sfr_window.sv =====
// ----------------------------------------------------------------------------
// sfr_window: window chain and match decision
// A row of cells holds the most recent bytes, newest in cell zero. On each
// accepted beat the row shifts, every cell checks its byte against the
// pattern, and the fill count decides what the beat emits.
// ----------------------------------------------------------------------------
module sfr_window #(
  parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [sfr_pkg::REG_W-1:0]    pat_bytes,
  input  logic [sfr_pkg::LEN_W-1:0]    pat_len,
  input  logic [sfr_pkg::LEN_W-1:0]    repl_len,
  input  logic                         pat_len_wr,
  input  logic                         acc,
  input  logic [sfr_pkg::BYTE_W-1:0]   in_byte,
  input  logic                         in_end,
  output sfr_pkg::sfr_job_t            job,
  output sfr_pkg::byte_row_t           win_row
);

  localparam int CAP = (PATTERN_MAX < sfr_pkg::MAX_BYTES) ? PATTERN_MAX : sfr_pkg::MAX_BYTES;
  localparam int LW  = $clog2(CAP + 1);

  logic [LW-1:0]              fill_r, fill_nxt;
  logic [LW-1:0]              plen, f0, f1;
  logic [sfr_pkg::LEN_W-1:0]  rlen;
  logic                       full, match;
  logic [sfr_pkg::BYTE_W-1:0] nb  [CAP];
  logic [sfr_pkg::BYTE_W-1:0] q   [CAP];
  logic [CAP-1:0]             eq_ok;
  sfr_pkg::byte_row_t         pat_row;

  // Clamp the lengths to what the hardware holds
  assign plen = (pat_len > sfr_pkg::LEN_W'(CAP)) ? LW'(CAP) : LW'(pat_len);
  assign rlen = (repl_len > sfr_pkg::LEN_W'(sfr_pkg::RCAP)) ?
                sfr_pkg::LEN_W'(sfr_pkg::RCAP) : repl_len;
  assign pat_row = pat_bytes;

  // Cell row: newest byte enters cell zero
  for (genvar j = 0; j < CAP; j++) begin : g_cell
    logic [sfr_pkg::LEN_W-1:0] pidx;
    logic                      cell_eq;

    if (j == 0) begin : g_head
      assign nb[j] = in_byte;
    end else begin : g_body
      assign nb[j] = q[j-1];
    end

    // Cell j holds the byte that sits at pattern position plen-1-j
    assign pidx = sfr_pkg::LEN_W'(plen) - sfr_pkg::LEN_W'(j) - sfr_pkg::LEN_W'(1);

    sfr_cell u_cell (
      .clk      (clk),
      .shift_en (acc),
      .d_in     (nb[j]),
      .pat_byte (pat_row[pidx[sfr_pkg::PTR_W-1:0]]),
      .q        (q[j]),
      .eq       (cell_eq)
    );

    assign eq_ok[j]   = (sfr_pkg::LEN_W'(j) >= sfr_pkg::LEN_W'(plen)) | cell_eq;
    assign win_row[j] = nb[j];
  end

  // Tie off byte positions beyond the window
  for (genvar k = CAP; k < sfr_pkg::MAX_BYTES; k++) begin : g_pad
    assign win_row[k] = '0;
  end

  assign match = &eq_ok;
  assign f0    = (fill_r >= plen) ? '0 : fill_r;
  assign f1    = f0 + LW'(1);
  assign full  = (f1 == plen);

  // Decide the results of the beat and the next fill
  always_comb begin
    job         = '0;
    job.str_end = in_end;
    fill_nxt    = fill_r;
    if (plen == '0) begin
      job.load  = 1'b1;
      job.chars = 1'b1;
      job.down  = 1'b1;
      job.cnt   = sfr_pkg::cnt_t'(1);
    end else if (full && match) begin
      fill_nxt = '0;
      if (rlen != '0) begin
        job.load     = 1'b1;
        job.chars    = 1'b1;
        job.src_repl = 1'b1;
        job.cnt      = sfr_pkg::cnt_t'(rlen);
      end else if (in_end) begin
        job.load = 1'b1;
        job.cnt  = sfr_pkg::cnt_t'(1);
      end
    end else if (full) begin
      // Pass the oldest byte, flush the rest at the end of the string
      job.load  = 1'b1;
      job.chars = 1'b1;
      job.down  = 1'b1;
      job.ptr   = sfr_pkg::ptr_t'(plen - LW'(1));
      job.cnt   = in_end ? sfr_pkg::cnt_t'(plen) : sfr_pkg::cnt_t'(1);
      fill_nxt  = in_end ? '0 : (plen - LW'(1));
    end else begin
      fill_nxt = in_end ? '0 : f1;
      if (in_end) begin
        job.load  = 1'b1;
        job.chars = 1'b1;
        job.down  = 1'b1;
        job.ptr   = sfr_pkg::ptr_t'(f1 - LW'(1));
        job.cnt   = sfr_pkg::cnt_t'(f1);
      end
    end
  end

  // Fill count: emptied on reset and on a pattern length write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (pat_len_wr) begin
      fill_r <= '0;
    end else if (acc) begin
      fill_r <= fill_nxt;
    end
  end

endmodule

// ===== hw/rtl/sfr_emit.sv =====
// ----------------------------------------------------------------------------
// sfr_emit: result sequencer and output register
// Holds the pending results of one beat and moves one of them per cycle into
// the output register while that register is free. Takes the next input beat
// while the last result of the current one moves out.
// ----------------------------------------------------------------------------
module sfr_emit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         acc,
  input  sfr_pkg::sfr_job_t            job,
  input  sfr_pkg::byte_row_t           win_row,
  input  logic [sfr_pkg::REG_W-1:0]    repl_bytes,
  output logic                         in_ready,
  output logic                         out_item_valid,
  input  logic                         out_ready,
  output logic [sfr_pkg::BYTE_W-1:0]   out_byte,
  output logic                         out_valid,
  output logic                         out_string_end,
  output logic                         out_run_last
);

  logic                       jact_r;
  sfr_pkg::byte_row_t         jrow_r;
  sfr_pkg::ptr_t              jptr_r;
  sfr_pkg::cnt_t              jleft_r;
  logic                       jdown_r, jchars_r, jend_r;
  logic                       o_vld_r;
  logic [sfr_pkg::BYTE_W-1:0] o_byte_r;
  logic                       o_chars_r, o_end_r, o_last_r;
  logic                       can_load, step, last_res;

  assign can_load = !o_vld_r || out_ready;
  assign step     = jact_r && can_load;
  assign last_res = (jleft_r == sfr_pkg::cnt_t'(1));
  assign in_ready = !jact_r || (last_res && can_load);

  // Pending-job control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jact_r <= 1'b0;
    end else if (acc) begin
      jact_r <= job.load;
    end else if (step && last_res) begin
      jact_r <= 1'b0;
    end
  end

  // Pending-job payload: load on accept, advance on each result
  always_ff @(posedge clk) begin
    if (acc) begin
      jrow_r   <= job.src_repl ? sfr_pkg::byte_row_t'(repl_bytes) : win_row;
      jptr_r   <= job.ptr;
      jleft_r  <= job.cnt;
      jdown_r  <= job.down;
      jchars_r <= job.chars;
      jend_r   <= job.str_end;
    end else if (step) begin
      jptr_r  <= jdown_r ? (jptr_r - sfr_pkg::ptr_t'(1)) : (jptr_r + sfr_pkg::ptr_t'(1));
      jleft_r <= jleft_r - sfr_pkg::cnt_t'(1);
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (step) begin
      o_vld_r <= 1'b1;
    end else if (out_ready) begin
      o_vld_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (step) begin
      o_byte_r  <= jchars_r ? jrow_r[jptr_r] : '0;
      o_chars_r <= jchars_r;
      o_end_r   <= jend_r && last_res;
      o_last_r  <= last_res;
    end
  end

  assign out_item_valid = o_vld_r;
  assign out_byte       = o_byte_r;
  assign out_valid      = o_chars_r;
  assign out_string_end = o_end_r;
  assign out_run_last   = o_last_r;

endmodule

// ===== hw/rtl/sfr_checker.sv =====
// ----------------------------------------------------------------------------
// sfr_checker: port-level checks for the stream find-and-replace core
// Watches the result channel for marker, end and stall rules; bound to the
// top level below.
// ----------------------------------------------------------------------------
module sfr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_item_valid,
  input logic                            out_ready,
  input logic [sfr_pkg::BYTE_W-1:0]      out_byte,
  input logic                            out_valid,
  input logic                            out_string_end,
  input logic                            out_run_last
);

  // A bare marker carries a zero byte and closes both the beat and the string
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item_valid && !out_valid) |-> (out_byte == '0 && out_string_end && out_run_last))
    else $error("bare end marker malformed");

  // The end of a string is always the last result of its input beat
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item_valid && out_string_end) |-> out_run_last)
    else $error("string end without run_last");

  // Hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item_valid && !out_ready) |=>
      (out_item_valid && $stable(out_byte) && $stable(out_valid) &&
       $stable(out_string_end) && $stable(out_run_last)))
    else $error("stalled result beat changed");

  // Drop any result beat out of reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_item_valid)
    else $error("result beat valid after reset");

endmodule

bind stream_find_replace_core sfr_checker u_sfr_checker (.*);
